FILE: rtl/msjd_pkg.sv
package msjd_pkg;

  // default sizes, overridable on the top level
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int MAX_SERVERS_DEF = 16;

  // port widths
  localparam int IN_DATA_W   = 56;
  localparam int IN_USER_W   = 1;
  localparam int OUT_DATA_W  = 80;
  localparam int OUT_USER_W  = 3;
  localparam int CFG_ADDR_W  = 1;
  localparam int CFG_DATA_W  = 6;

  // register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_QUEUE_LIMIT  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_SERVER_COUNT = 1'd1;

  // item kinds on the input side
  localparam logic MODE_ARRIVAL     = 1'b0;
  localparam logic MODE_SERVICE_END = 1'b1;

  // result status codes
  localparam logic [2:0] ST_STARTED    = 3'd0;
  localparam logic [2:0] ST_QUEUED     = 3'd1;
  localparam logic [2:0] ST_DROPPED    = 3'd2;
  localparam logic [2:0] ST_DONE_IDLE  = 3'd3;
  localparam logic [2:0] ST_DONE_NEXT  = 3'd4;
  localparam logic [2:0] ST_SPURIOUS   = 3'd5;

  typedef struct packed {
    logic capture;  // latch item, launch table reads
    logic commit;   // apply update, load result register
  } msjd_cmd_t;

  typedef struct packed {
    logic out_free; // result register empty or being drained
  } msjd_stat_t;

endpackage

FILE: rtl/msjd_ram.sv
module msjd_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/msjd_ctrl.sv
module msjd_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  msjd_pkg::msjd_stat_t  stat,
  output msjd_pkg::msjd_cmd_t   cmd
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state;
  logic state_next;

  assign s_tready = (state == ST_IDLE);

  always_comb begin
    cmd.capture = 1'b0;
    cmd.commit  = 1'b0;
    state_next  = state;
    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          state_next  = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // table read data is ready; wait only for room in the result register
        if (stat.out_free) begin
          cmd.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/msjd_datapath.sv
module msjd_datapath #(
  parameter int QUEUE_DEPTH = msjd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_SERVERS = msjd_pkg::MAX_SERVERS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  msjd_pkg::msjd_cmd_t                cmd,
  output msjd_pkg::msjd_stat_t               stat,
  input  logic [msjd_pkg::IN_DATA_W-1:0]     s_tdata,
  input  logic [msjd_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                               m_tvalid,
  input  logic                               m_tready,
  output logic [msjd_pkg::OUT_DATA_W-1:0]    m_tdata,
  output logic [msjd_pkg::OUT_USER_W-1:0]    m_tuser,
  input  logic                               cfg_we,
  input  logic [msjd_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [msjd_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int QW  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW  = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int SCW = $clog2(MAX_SERVERS + 1);

  // configuration
  logic signed [5:0] queue_limit;
  logic [SCW-1:0]    server_count;

  // queue and pool bookkeeping
  logic [QW-1:0]          wait_head, wait_head_next;
  logic [QCW-1:0]         wait_count, wait_count_next;
  logic [SW-1:0]          idle_head, idle_head_next;
  logic [SCW-1:0]         idle_count, idle_count_next;
  logic [MAX_SERVERS-1:0] busy_mask, busy_mask_next;
  logic [MAX_SERVERS-1:0] idle_valid, idle_valid_next;

  // latched item
  logic        in_mode;
  logic [15:0] in_tag;
  logic [3:0]  in_sid;
  logic [31:0] in_now;

  // table ports
  logic [SW-1:0] idle_raddr, idle_waddr, held_raddr, held_waddr;
  logic [QW-1:0] wait_waddr;
  logic          idle_we, held_we, wait_we;
  logic [SW-1:0] idle_q;
  logic [15:0]   held_wdata, held_q, wtag_q;
  logic [31:0]   warr_q;

  // result fields
  logic [2:0]  r_status;
  logic        r_done_valid, r_start_valid;
  logic [15:0] r_done_tag, r_start_tag;
  logic [SW-1:0] r_start_srv;
  logic [31:0] r_wait_time;

  logic [SCW-1:0] cfg_n;
  logic [SW-1:0]  sid_idx, idle_srv;
  logic [QCW:0]   wait_tail_sum;
  logic [SCW:0]   idle_tail_sum;
  logic [SW-1:0]  idle_tail;
  logic           q_full, sid_bad;

  assign stat.out_free = !m_tvalid || m_tready;

  assign idle_raddr = idle_head;
  assign held_raddr = SW'(s_tdata[19:16]);

  msjd_ram #(.WIDTH(SW), .DEPTH(MAX_SERVERS)) u_idle_ram (
    .clk(clk), .we(idle_we), .waddr(idle_waddr), .wdata(SW'(sid_idx)),
    .re(cmd.capture), .raddr(idle_raddr), .rdata(idle_q)
  );

  msjd_ram #(.WIDTH(16), .DEPTH(MAX_SERVERS)) u_held_ram (
    .clk(clk), .we(held_we), .waddr(held_waddr), .wdata(held_wdata),
    .re(cmd.capture), .raddr(held_raddr), .rdata(held_q)
  );

  msjd_ram #(.WIDTH(16), .DEPTH(QUEUE_DEPTH)) u_wtag_ram (
    .clk(clk), .we(wait_we), .waddr(wait_waddr), .wdata(in_tag),
    .re(cmd.capture), .raddr(wait_head), .rdata(wtag_q)
  );

  msjd_ram #(.WIDTH(32), .DEPTH(QUEUE_DEPTH)) u_warr_ram (
    .clk(clk), .we(wait_we), .waddr(wait_waddr), .wdata(in_now),
    .re(cmd.capture), .raddr(wait_head), .rdata(warr_q)
  );

  // server count clamped to 1 .. MAX_SERVERS
  always_comb begin
    if (cfg_data[4:0] == 5'd0) begin
      cfg_n = SCW'(1);
    end else if (int'(cfg_data[4:0]) > MAX_SERVERS) begin
      cfg_n = SCW'(MAX_SERVERS);
    end else begin
      cfg_n = SCW'(cfg_data[4:0]);
    end
  end

  always_comb begin
    sid_idx  = SW'(in_sid);
    // an idle-list entry never written since the pool restart holds its own index
    idle_srv = idle_valid[idle_head] ? idle_q : idle_head;

    wait_tail_sum = (QCW+1)'(wait_head) + (QCW+1)'(wait_count);
    if (wait_tail_sum >= (QCW+1)'(QUEUE_DEPTH)) begin
      wait_tail_sum = wait_tail_sum - (QCW+1)'(QUEUE_DEPTH);
    end
    wait_waddr = QW'(wait_tail_sum);

    idle_tail_sum = (SCW+1)'(idle_head) + (SCW+1)'(idle_count);
    if (idle_tail_sum >= (SCW+1)'(MAX_SERVERS)) begin
      idle_tail_sum = idle_tail_sum - (SCW+1)'(MAX_SERVERS);
    end
    idle_tail = SW'(idle_tail_sum);

    q_full = (int'(wait_count) >= QUEUE_DEPTH) ||
             (!queue_limit[5] && (int'(wait_count) >= int'(queue_limit)));
    sid_bad = (int'(in_sid) >= MAX_SERVERS) ||
              (int'(in_sid) >= int'(server_count)) ||
              !busy_mask[sid_idx];

    wait_head_next  = wait_head;
    wait_count_next = wait_count;
    idle_head_next  = idle_head;
    idle_count_next = idle_count;
    busy_mask_next  = busy_mask;
    idle_valid_next = idle_valid;
    idle_we    = 1'b0;
    idle_waddr = idle_tail;
    held_we    = 1'b0;
    held_waddr = sid_idx;
    held_wdata = in_tag;
    wait_we    = 1'b0;

    r_status      = msjd_pkg::ST_STARTED;
    r_done_valid  = 1'b0;
    r_done_tag    = 16'd0;
    r_start_valid = 1'b0;
    r_start_srv   = '0;
    r_start_tag   = 16'd0;
    r_wait_time   = 32'd0;

    if (in_mode == msjd_pkg::MODE_ARRIVAL) begin
      if (idle_count != '0) begin
        if (idle_head == SW'(MAX_SERVERS - 1)) begin
          idle_head_next = '0;
        end else begin
          idle_head_next = idle_head + SW'(1);
        end
        idle_count_next = idle_count - SCW'(1);
        busy_mask_next[idle_srv] = 1'b1;
        held_we       = 1'b1;
        held_waddr    = idle_srv;
        held_wdata    = in_tag;
        r_status      = msjd_pkg::ST_STARTED;
        r_start_valid = 1'b1;
        r_start_srv   = idle_srv;
        r_start_tag   = in_tag;
      end else if (q_full) begin
        r_status = msjd_pkg::ST_DROPPED;
      end else begin
        wait_we         = 1'b1;
        wait_count_next = wait_count + QCW'(1);
        r_status        = msjd_pkg::ST_QUEUED;
      end
    end else begin
      if (sid_bad) begin
        r_status = msjd_pkg::ST_SPURIOUS;
      end else begin
        r_done_valid = 1'b1;
        r_done_tag   = held_q;
        if (wait_count != '0) begin
          held_we       = 1'b1;
          held_waddr    = sid_idx;
          held_wdata    = wtag_q;
          r_start_valid = 1'b1;
          r_start_srv   = sid_idx;
          r_start_tag   = wtag_q;
          r_wait_time   = in_now - warr_q;
          if (wait_head == QW'(QUEUE_DEPTH - 1)) begin
            wait_head_next = '0;
          end else begin
            wait_head_next = wait_head + QW'(1);
          end
          wait_count_next = wait_count - QCW'(1);
          r_status        = msjd_pkg::ST_DONE_NEXT;
        end else begin
          busy_mask_next[sid_idx] = 1'b0;
          idle_we                 = 1'b1;
          idle_valid_next[idle_tail] = 1'b1;
          idle_count_next         = idle_count + SCW'(1);
          r_status                = msjd_pkg::ST_DONE_IDLE;
        end
      end
    end

    if (!cmd.commit) begin
      idle_we = 1'b0;
      held_we = 1'b0;
      wait_we = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      in_mode <= s_tuser[0];
      in_tag  <= s_tdata[15:0];
      in_sid  <= s_tdata[19:16];
      in_now  <= s_tdata[51:20];
    end
    if (cmd.commit) begin
      m_tuser <= r_status;
      m_tdata <= {5'(server_count - idle_count_next),
                  5'(wait_count_next),
                  r_wait_time,
                  r_start_tag,
                  4'(r_start_srv),
                  r_start_valid,
                  r_done_tag,
                  r_done_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid     <= 1'b0;
      queue_limit  <= -6'sd1;
      server_count <= SCW'(1);
      idle_count   <= SCW'(1);
      idle_head    <= '0;
      idle_valid   <= '0;
      busy_mask    <= '0;
      wait_head    <= '0;
      wait_count   <= '0;
    end else begin
      if (cmd.commit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      if (cfg_we) begin
        if (cfg_addr == msjd_pkg::REG_QUEUE_LIMIT) begin
          queue_limit <= signed'(cfg_data);
        end else begin
          // pool restart
          server_count <= cfg_n;
          idle_count   <= cfg_n;
          idle_head    <= '0;
          idle_valid   <= '0;
          busy_mask    <= '0;
          wait_head    <= '0;
          wait_count   <= '0;
        end
      end else if (cmd.commit) begin
        idle_count <= idle_count_next;
        idle_head  <= idle_head_next;
        idle_valid <= idle_valid_next;
        busy_mask  <= busy_mask_next;
        wait_head  <= wait_head_next;
        wait_count <= wait_count_next;
      end
    end
  end

endmodule

FILE: rtl/multi_server_job_dispatcher.sv
// Job dispatcher for a pool of servers with a bounded waiting queue. Each
// input item is either a job arrival (s_tuser = 0) or the end of service on
// one server (s_tuser = 1), and gives exactly one result item. A capture step
// launches the reads of the idle-server list, the per-server job table and
// the head of the waiting queue (all registered-read RAMs), a commit step
// updates them and loads the result register. No new item is taken until
// the last one is committed; a full result register that is not drained
// holds it longer. Writing server_count restarts the pool at once: the idle
// list becomes 0 .. n-1, all servers are idle and the queue is emptied.
// Configuration writes are to be made only while no item is in flight.
module multi_server_job_dispatcher #(
  parameter int QUEUE_DEPTH = msjd_pkg::QUEUE_DEPTH_DEF,
  parameter int MAX_SERVERS = msjd_pkg::MAX_SERVERS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // job_tag[15:0], server_id[19:16], now[51:20], zero fill above
  input  logic [msjd_pkg::IN_DATA_W-1:0]    s_tdata,
  // mode[0]
  input  logic [msjd_pkg::IN_USER_W-1:0]    s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // done_valid[0], done_tag[16:1], start_valid[17], start_server[21:18],
  // start_tag[37:22], wait_time[69:38], queue_length[74:70], busy_servers[79:75]
  output logic [msjd_pkg::OUT_DATA_W-1:0]   m_tdata,
  // status[2:0]
  output logic [msjd_pkg::OUT_USER_W-1:0]   m_tuser,
  input  logic                              cfg_we,
  input  logic [msjd_pkg::CFG_ADDR_W-1:0]   cfg_addr,
  input  logic [msjd_pkg::CFG_DATA_W-1:0]   cfg_data
);

  msjd_pkg::msjd_cmd_t  cmd;
  msjd_pkg::msjd_stat_t stat;

  msjd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  msjd_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .MAX_SERVERS (MAX_SERVERS)
  ) u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cfg_we   (cfg_we),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data)
  );

endmodule
